>>> hdl/tcw_pkg.sv
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned CUR_W  = 11;
  localparam int unsigned SUM_W  = CUR_W + 1;
  localparam int unsigned CELL_W = 16;

  // Job queue between front and back; depth is a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  // Input command codes
  localparam logic [1:0] CMD_PUT       = 2'd0;
  localparam logic [1:0] CMD_BACKSPACE = 2'd1;
  localparam logic [1:0] CMD_CLEAR     = 2'd2;
  localparam logic [1:0] CMD_READ      = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_ATTR = 2'd1;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_READ_NONE
  } tcw_op_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       character;
    logic [CUR_W-1:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [CUR_W-1:0] cursor;
    logic [7:0]       read_character;
    logic [7:0]       read_attribute;
  } tcw_out_t;

  typedef struct packed {
    tcw_op_e           op;
    logic [7:0]        character;
    logic [ADDR_W-1:0] cell_index;
  } tcw_job_t;

  typedef struct packed {
    logic [7:0] text_attr;
    logic [7:0] clear_attr;
  } tcw_cfg_t;

endpackage

`default_nettype wire

>>> hdl/tcw_front.sv
// Front end: accepts input items and classifies them into jobs.
`default_nettype none

module tcw_front (
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tcw_pkg::tcw_in_t  in_data_i,
  input  wire logic              run_i,
  input  wire logic              q_ready_i,
  output logic                   push_o,
  output tcw_pkg::tcw_job_t      job_o
);
  import tcw_pkg::*;

  assign in_ready_o = run_i && q_ready_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    job_o.character  = in_data_i.character;
    job_o.cell_index = in_data_i.cell_index[ADDR_W-1:0];
    unique case (in_data_i.command)
      CMD_PUT: begin
        job_o.op = (in_data_i.character == CHAR_NEWLINE) ? OP_NEWLINE : OP_PUT;
      end
      CMD_BACKSPACE: job_o.op = OP_BACKSPACE;
      CMD_CLEAR:     job_o.op = OP_CLEAR;
      default: begin
        // out-of-range reads answer zeros without touching memory
        job_o.op = (in_data_i.cell_index < CUR_W'(CELLS)) ? OP_READ : OP_READ_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/tcw_fifo.sv
// Short job queue between the front end and the back end.
`default_nettype none

module tcw_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire tcw_pkg::tcw_job_t  data_i,
  output logic                    ready_o,
  output logic                    valid_o,
  output tcw_pkg::tcw_job_t       data_o,
  input  wire logic               pop_i
);
  import tcw_pkg::*;

  tcw_job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]     count_q;

  assign ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i && !pop_i)      count_q <= count_q + QCNT_W'(1);
      else if (pop_i && !push_i) count_q <= count_q - QCNT_W'(1);
    end
  end

  push_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into full job queue");

  pop_when_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty job queue");

  count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("job queue count overflow");

endmodule

`default_nettype wire

>>> hdl/tcw_back.sv
// Back end: screen memory, cursor and the sequencer that carries out jobs.
`default_nettype none

module tcw_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tcw_pkg::tcw_cfg_t  cfg_i,
  input  wire logic               job_valid_i,
  input  wire tcw_pkg::tcw_job_t  job_i,
  output logic                    job_pop_o,
  output logic                    run_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tcw_pkg::tcw_out_t       out_data_o
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BS_WAIT,
    ST_BS_PREV,
    ST_RD_WAIT,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                pend_q;
  logic [CUR_W-1:0]    cursor_q;
  logic [COL_W-1:0]    col_q;
  logic                out_valid_q;
  tcw_out_t            out_q;

  logic [CELL_W-1:0]   mem [CELLS];
  logic [CELL_W-1:0]   rd_data_q;
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [CELL_W-1:0]   wr_data;

  logic                pop;
  logic [SUM_W-1:0]    put_next, nl_next;
  logic [SUM_W-1:0]    adv_next;
  logic                adv_scroll;
  logic                res_load;
  logic [COL_W-1:0]    col_inc, col_dec;

  assign run_o       = (state_q != ST_INIT);
  assign job_pop_o   = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign put_next = SUM_W'(cursor_q) + SUM_W'(1);
  assign nl_next  = SUM_W'(cursor_q) + (SUM_W'(COLUMNS) - SUM_W'(col_q));
  assign col_inc  = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
  assign col_dec  = (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - COL_W'(1);

  assign adv_next   = (job_i.op == OP_PUT) ? put_next : nl_next;
  assign adv_scroll = (adv_next >= SUM_W'(CELLS));

  // Start a job only when the result register is free by the time it is done
  assign pop = (state_q == ST_IDLE) && job_valid_i && (!out_valid_q || out_ready_i);

  // A job finishes and loads the result register
  always_comb begin
    res_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        res_load = pop && ((((job_i.op == OP_PUT) || (job_i.op == OP_NEWLINE)) &&
                            !adv_scroll) || (job_i.op == OP_READ_NONE));
      end
      ST_BS_WAIT:             res_load = (cursor_q == '0);
      ST_BS_PREV, ST_RD_WAIT: res_load = 1'b1;
      ST_FILL, ST_CLEAR:      res_load = (cnt_q == CNT_W'(CELLS - 1));
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q[ADDR_W-1:0];
        wr_data = {RESET_ATTR, CHAR_SPACE};
      end
      ST_IDLE: begin
        if (pop) begin
          unique case (job_i.op)
            OP_PUT: begin
              wr_en   = 1'b1;
              wr_addr = cursor_q[ADDR_W-1:0];
              wr_data = {cfg_i.text_attr, job_i.character};
            end
            OP_BACKSPACE: begin
              rd_en   = 1'b1;
              rd_addr = cursor_q[ADDR_W-1:0];
            end
            OP_READ: begin
              rd_en   = 1'b1;
              rd_addr = job_i.cell_index;
            end
            default: ;
          endcase
        end
      end
      ST_BS_WAIT: begin
        // keep the cell's attribute, blank its character
        wr_en   = 1'b1;
        wr_addr = cursor_q[ADDR_W-1:0];
        wr_data = {rd_data_q[15:8], CHAR_SPACE};
      end
      ST_BS_PREV: begin
        wr_en   = 1'b1;
        wr_addr = cursor_q[ADDR_W-1:0] - ADDR_W'(1);
        wr_data = {cfg_i.text_attr, CHAR_SPACE};
      end
      ST_SCROLL: begin
        // read one row ahead, write the previous read one row up
        rd_en   = (cnt_q < CNT_W'(CELLS));
        rd_addr = cnt_q[ADDR_W-1:0];
        wr_en   = pend_q;
        wr_addr = cnt_q[ADDR_W-1:0] - ADDR_W'(COLUMNS + 1);
        wr_data = rd_data_q;
      end
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q[ADDR_W-1:0];
        wr_data = {cfg_i.text_attr, CHAR_SPACE};
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q[ADDR_W-1:0];
        wr_data = {cfg_i.clear_attr, CHAR_SPACE};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      cursor_q    <= '0;
      col_q       <= '0;
      out_q       <= '0;
    end else begin
      unique case (state_q)
        ST_INIT: begin
          if (cnt_q == CNT_W'(CELLS - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_IDLE: begin
          if (pop) begin
            unique case (job_i.op)
              OP_PUT, OP_NEWLINE: begin
                if (job_i.op == OP_PUT) begin
                  col_q <= col_inc;
                end else begin
                  col_q <= '0;
                end
                if (adv_scroll) begin
                  cursor_q <= CUR_W'(adv_next - SUM_W'(COLUMNS));
                  cnt_q    <= CNT_W'(COLUMNS);
                  pend_q   <= 1'b0;
                  state_q  <= ST_SCROLL;
                end else begin
                  cursor_q <= CUR_W'(adv_next);
                  out_q <= '{cursor: CUR_W'(adv_next),
                             read_character: 8'd0, read_attribute: 8'd0};
                end
              end
              OP_BACKSPACE: state_q <= ST_BS_WAIT;
              OP_CLEAR: begin
                cnt_q   <= '0;
                state_q <= ST_CLEAR;
              end
              OP_READ: state_q <= ST_RD_WAIT;
              OP_READ_NONE: begin
                out_q <= '{cursor: cursor_q, read_character: 8'd0, read_attribute: 8'd0};
              end
              default: ;
            endcase
          end
        end
        ST_BS_WAIT: begin
          if (cursor_q == '0) begin
            out_q   <= '{cursor: '0, read_character: 8'd0, read_attribute: 8'd0};
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_BS_PREV;
          end
        end
        ST_BS_PREV: begin
          cursor_q    <= cursor_q - CUR_W'(1);
          col_q       <= col_dec;
          out_q   <= '{cursor: cursor_q - CUR_W'(1), read_character: 8'd0,
                       read_attribute: 8'd0};
          state_q <= ST_IDLE;
        end
        ST_RD_WAIT: begin
          out_q   <= '{cursor: cursor_q, read_character: rd_data_q[7:0],
                       read_attribute: rd_data_q[15:8]};
          state_q <= ST_IDLE;
        end
        ST_SCROLL: begin
          if (cnt_q < CNT_W'(CELLS)) begin
            cnt_q  <= cnt_q + CNT_W'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q  <= 1'b0;
            cnt_q   <= CNT_W'(CELLS - COLUMNS);
            state_q <= ST_FILL;
          end
        end
        ST_FILL: begin
          if (cnt_q == CNT_W'(CELLS - 1)) begin
            out_q   <= '{cursor: cursor_q, read_character: 8'd0, read_attribute: 8'd0};
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_CLEAR: begin
          if (cnt_q == CNT_W'(CELLS - 1)) begin
            cursor_q    <= '0;
            col_q       <= '0;
            out_q   <= '{cursor: '0, read_character: 8'd0, read_attribute: 8'd0};
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  cursor_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q < CUR_W'(CELLS))
    else $error("cursor beyond last cell");

  column_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < COL_W'(COLUMNS))
    else $error("cursor column beyond row");

  pop_needs_free_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!out_valid_q || out_ready_i))
    else $error("job started while result register is held");

  write_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr < ADDR_W'(CELLS)))
    else $error("screen write beyond last cell");

endmodule

`default_nettype wire

>>> hdl/text_console_writer.sv
// Text console writer top level: 80 by 25 character-cell screen with a cursor.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) carries commands: put a
// character (10 is newline), backspace, clear screen, or read one cell. Each
// transfer yields exactly one result on the output channel
// (out_valid_o/out_ready_i/out_data_o) with the cursor after the command and,
// for a read, the addressed cell's character and attribute.
// The config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i) writes
// the text attribute (index 0) or the clear attribute (index 1); it is always
// ready and should only be used while the block is idle.
// Every command passes the two-entry job queue. A put, newline or
// out-of-range read loads its result as the sequencer starts it; a read or
// backspace waits for the screen memory's registered read and loads its
// result before the next job starts. Puts and newlines sustain one per cycle
// while results are taken and nothing scrolls. A put or newline that passes
// the last cell scrolls (one cell moved per cycle, then the bottom row filled).
// After reset a clearing pass writes every cell to a space with attribute 7,
// with in_ready_o low; config writes are still taken. When the receiver
// stalls, the result is held and up to two more items are taken into the
// queue before in_ready_o drops.
`default_nettype none

module text_console_writer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire tcw_pkg::tcw_in_t                 in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output tcw_pkg::tcw_out_t                     out_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [7:0]                       cfg_data_i
);
  import tcw_pkg::*;

  tcw_cfg_t cfg_q;
  logic     run;
  logic     q_ready, push, job_valid, job_pop;
  tcw_job_t job_in, job_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_attr  <= RESET_ATTR;
      cfg_q.clear_attr <= RESET_ATTR;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TEXT_ATTR:  cfg_q.text_attr  <= cfg_data_i;
        REG_CLEAR_ATTR: cfg_q.clear_attr <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcw_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .run_i      (run),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .job_o      (job_in)
  );

  tcw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .ready_o (q_ready),
    .valid_o (job_valid),
    .data_o  (job_out),
    .pop_i   (job_pop)
  );

  tcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .run_o       (run),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> sim/text_console_writer_tb.sv
// Testbench for the text console writer: directed and random command streams checked against a screen mirror.
`timescale 1ns / 100ps

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int unsigned STALL_LIMIT     = 20000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned CHUNKS          = 6;
  localparam int unsigned CHUNK_ITEMS     = 188;
  localparam int unsigned REPORT_LIMIT    = 10;

  // Mirror of the screen and cursor; predicts one result per command
  class console_mirror;
    logic [15:0]  cells [CELLS];
    int unsigned  cursor_pos;
    logic [7:0]   text_attr;
    logic [7:0]   clear_attr;
    tcw_out_t     pending_results[$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  scrolls;
    int unsigned  clears;
    int unsigned  reads;

    function new();
      text_attr  = RESET_ATTR;
      clear_attr = RESET_ATTR;
      cursor_pos = 0;
      mismatches = 0;
      checked    = 0;
      scrolls    = 0;
      clears     = 0;
      reads      = 0;
      fill_screen(RESET_ATTR);
    endfunction

    function void fill_screen(logic [7:0] attr);
      foreach (cells[k]) cells[k] = {attr, CHAR_SPACE};
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [7:0] value);
      case (index)
        REG_TEXT_ATTR:  text_attr = value;
        REG_CLEAR_ATTR: clear_attr = value;
        default: ;
      endcase
    endfunction

    function void note_command(tcw_in_t cmd);
      tcw_out_t    res;
      int unsigned pos;
      int unsigned k;
      res = '0;
      pos = cursor_pos;
      case (cmd.command)
        CMD_PUT: begin
          if (cmd.character == CHAR_NEWLINE) begin
            pos = (pos / COLUMNS + 1) * COLUMNS;
          end else begin
            cells[pos] = {text_attr, cmd.character};
            pos++;
          end
          // Scroll up one row once the cursor runs off the screen
          if (pos >= CELLS) begin
            for (k = 0; k < CELLS - COLUMNS; k++) cells[k] = cells[k + COLUMNS];
            for (k = CELLS - COLUMNS; k < CELLS; k++) cells[k] = {text_attr, CHAR_SPACE};
            pos -= COLUMNS;
            scrolls++;
          end
        end
        CMD_BACKSPACE: begin
          cells[pos][7:0] = CHAR_SPACE;
          if (pos != 0) begin
            cells[pos - 1] = {text_attr, CHAR_SPACE};
            pos--;
          end
        end
        CMD_CLEAR: begin
          fill_screen(clear_attr);
          pos = 0;
          clears++;
        end
        default: begin
          reads++;
          if (cmd.cell_index < CELLS)
            {res.read_attribute, res.read_character} = cells[cmd.cell_index];
        end
      endcase
      cursor_pos = pos;
      res.cursor = CUR_W'(pos);
      pending_results.push_back(res);
    endfunction

    function void check_result(tcw_out_t got);
      tcw_out_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result cursor %0d char %02h attr %02h", $time,
                   got.cursor, got.read_character, got.read_attribute);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.cursor !== want.cursor || got.read_character !== want.read_character ||
          got.read_attribute !== want.read_attribute) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result %0d: expected cursor %0d char %02h attr %02h",
                   $time, checked, want.cursor, want.read_character, want.read_attribute);
          $display("%0t: result %0d: actual   cursor %0d char %02h attr %02h",
                   $time, checked, got.cursor, got.read_character, got.read_attribute);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  tcw_in_t              in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  tcw_out_t             out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]           cfg_data_i = '0;

  console_mirror mirror = new();
  int unsigned   items_sent = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  logic          hold_off_req = 1'b0;
  int unsigned   quiet_cycles = 0;

  text_console_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Abort when nothing transfers for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("text_console_writer_tb failed");
        $finish;
      end
    end
  end

  // Result side: check, then pick next ready; one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    logic        held_once;
    hold_left = 0;
    held_once = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) mirror.check_result(out_data_o);
      if (hold_off_req && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] random_char();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [CUR_W-1:0] random_index();
    return CUR_W'($urandom);
  endfunction

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 15) == 0) return random_char();
    return 8'($urandom_range(32, 126));
  endfunction

  // Half the time cells at or just behind the cursor, otherwise anywhere in the index range
  function automatic logic [CUR_W-1:0] read_target();
    if ($urandom_range(0, 1) == 0) return random_index();
    return CUR_W'((mirror.cursor_pos + CELLS - $urandom_range(0, 8)) % CELLS);
  endfunction

  task automatic issue_command(input logic [1:0] code, input logic [7:0] ch,
                               input logic [CUR_W-1:0] idx);
    tcw_in_t item;
    item.command    = code;
    item.character  = ch;
    item.cell_index = idx;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.note_command(item);
    items_sent++;
  endtask

  task automatic set_attributes(input logic [7:0] text_value, input logic [7:0] clear_value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_TEXT_ATTR;
    cfg_data_i  <= text_value;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.write_register(REG_TEXT_ATTR, text_value);
    cfg_index_i <= REG_CLEAR_ATTR;
    cfg_data_i  <= clear_value;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.write_register(REG_CLEAR_ATTR, clear_value);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Text lines with reads and backspaces mixed in, plus rare clears and noise
  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int unsigned roll;
    int unsigned len;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        issue_command(CMD_CLEAR, random_char(), random_index());
      end else if (roll < 13) begin
        repeat ($urandom_range(1, 4)) issue_command(CMD_BACKSPACE, random_char(), random_index());
      end else if (roll < 43) begin
        repeat ($urandom_range(1, 3)) issue_command(CMD_READ, random_char(), read_target());
      end else if (roll < 48) begin
        issue_command(2'($urandom_range(0, 3)), random_char(), random_index());
      end else begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 12);
        repeat (len) issue_command(CMD_PUT, text_char(), random_index());
        if ($urandom_range(0, 5) != 0) issue_command(CMD_PUT, CHAR_NEWLINE, random_index());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned chunk;
    logic [7:0]  text_value;
    logic [7:0]  clear_value;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset contents, edge bytes, backspace corners, reads out of range
    issue_command(CMD_READ, 8'h00, 11'd0);
    issue_command(CMD_BACKSPACE, 8'h00, 11'd0);
    issue_command(CMD_PUT, 8'h00, 11'd0);
    issue_command(CMD_PUT, 8'hFF, 11'd0);
    issue_command(CMD_PUT, 8'h41, 11'd0);
    issue_command(CMD_READ, 8'h00, 11'd0);
    issue_command(CMD_READ, 8'h00, 11'd1);
    issue_command(CMD_READ, 8'h00, 11'd2);
    issue_command(CMD_BACKSPACE, 8'h00, 11'd0);
    issue_command(CMD_READ, 8'h00, 11'd1);
    issue_command(CMD_READ, 8'h00, 11'd2);
    issue_command(CMD_READ, 8'hFF, CUR_W'(CELLS - 1));
    issue_command(CMD_READ, 8'hFF, CUR_W'(CELLS));
    issue_command(CMD_READ, 8'hFF, 11'h7FF);
    issue_command(CMD_PUT, CHAR_NEWLINE, 11'h7FF);
    issue_command(CMD_PUT, 8'h5A, 11'h7FF);
    issue_command(CMD_BACKSPACE, 8'hFF, 11'h7FF);
    issue_command(CMD_BACKSPACE, 8'hFF, 11'h7FF);
    issue_command(CMD_READ, 8'h00, 11'd79);
    issue_command(CMD_CLEAR, 8'hFF, 11'h7FF);
    issue_command(CMD_READ, 8'h00, 11'd0);
    issue_command(CMD_BACKSPACE, 8'h00, 11'd0);
    wait_for_results();

    for (chunk = 0; chunk < CHUNKS; chunk++) begin
      case (chunk)
        0:       begin text_value = 8'hFF; clear_value = 8'h00; end
        1:       begin text_value = 8'h00; clear_value = 8'hFF; end
        default: begin text_value = random_char(); clear_value = random_char(); end
      endcase
      set_attributes(text_value, clear_value);
      if (chunk < 2) begin
        send_idle_pct <= 38;
        recv_idle_pct <= 88;
      end else if (chunk < 4) begin
        send_idle_pct <= 88;
        recv_idle_pct <= 38;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      // Stall the result side for a long stretch while commands keep coming
      if (chunk == 4) hold_off_req <= 1'b1;
      run_random(CHUNK_ITEMS);
      wait_for_results();
    end

    $display("Sent %0d commands: %0d reads, %0d clears, %0d scrolls predicted",
             items_sent, mirror.reads, mirror.clears, mirror.scrolls);
    $display("Compared %0d results, %0d mismatches", mirror.checked, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.pending_results.size() == 0) begin
      $display("text_console_writer_tb passed");
    end else begin
      $display("text_console_writer_tb failed");
    end
    $finish;
  end

endmodule
